### hdl/wnwt_pkg.sv
package wnwt_pkg;

    localparam int COORD_W = 24;
    localparam int MAG_W   = 24;
    localparam int SQ_W    = 48;
    localparam int DIST_W  = 50;
    localparam int CNT_IN_W = 11;
    localparam int IDX_OUT_W = 10;

    localparam logic [DIST_W-1:0] FAR_THRESHOLD_SQ = DIST_W'(250000);

    typedef enum logic [1:0] {
        REQ_WRITE   = 2'd0,
        REQ_QUERY   = 2'd1,
        REQ_RESTART = 2'd2,
        REQ_NONE    = 2'd3
    } req_t;

    typedef struct packed {
        logic wr_en;
        logic load_loc;
        logic issue;
        logic init;
    } cmd_t;

    typedef struct packed {
        logic pipe_busy;
        logic far;
    } sts_t;

endpackage

### hdl/windowed_nearest_waypoint_tracker.sv
// channel   | handshake                  | payload
// ----------+----------------------------+-----------------------------------------------
// request   | start, busy (taken: !busy) | req_type, point_index, coord_x/y/z
// config    | cfg_valid, cfg_ready       | cfg_data (point_count)
// result    | result_valid (one cycle)   | nearest_index, nearest_dist_sq, used_full_scan
//
// write and restart words leave busy low
// query: one read of the tracked point, then one read per window point (up to BACK_RADIUS+FWD_RADIUS+1),
// through the single read port of the point table, then a drain of the 5-stage distance pipe
// far fallback adds (point_count - tracked) reads and another drain; empty table answers next cycle
// rst_n clears control, tracked index and count; the point table is not cleared
// the receiver cannot stall: result_valid is high for exactly one cycle per result
module windowed_nearest_waypoint_tracker
    import wnwt_pkg::*;
#(
    parameter int MAX_POINTS  = 1024,
    parameter int BACK_RADIUS = 2,
    parameter int FWD_RADIUS  = 12
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                req_type,
    input  logic [9:0]                point_index,
    input  logic signed [COORD_W-1:0] coord_x,
    input  logic signed [COORD_W-1:0] coord_y,
    input  logic signed [COORD_W-1:0] coord_z,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CNT_IN_W-1:0]       cfg_data,
    output logic                      result_valid,
    output logic [IDX_OUT_W-1:0]      nearest_index,
    output logic [DIST_W-1:0]         nearest_dist_sq,
    output logic                      used_full_scan
);

    localparam int IDX_W = $clog2(MAX_POINTS);

    cmd_t              cmd;
    sts_t              sts;
    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  best_idx;
    logic [DIST_W-1:0] best_d;

    assign cfg_ready = 1'b1;

    wnwt_ctrl #(
        .MAX_POINTS  (MAX_POINTS),
        .BACK_RADIUS (BACK_RADIUS),
        .FWD_RADIUS  (FWD_RADIUS)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .req_type        (req_type),
        .busy            (busy),
        .cfg_valid       (cfg_valid),
        .cfg_data        (cfg_data),
        .cmd             (cmd),
        .rd_addr         (rd_addr),
        .sts             (sts),
        .best_idx        (best_idx),
        .best_d          (best_d),
        .result_valid    (result_valid),
        .nearest_index   (nearest_index),
        .nearest_dist_sq (nearest_dist_sq),
        .used_full_scan  (used_full_scan)
    );

    wnwt_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .rd_addr     (rd_addr),
        .point_index (point_index),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .coord_z     (coord_z),
        .sts         (sts),
        .best_idx    (best_idx),
        .best_d      (best_d)
    );

endmodule

### hdl/wnwt_datapath.sv
module wnwt_datapath
    import wnwt_pkg::*;
#(
    parameter int MAX_POINTS = 1024,
    localparam int IDX_W = $clog2(MAX_POINTS)
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cmd_t                       cmd,
    input  logic [IDX_W-1:0]           rd_addr,
    input  logic [9:0]                 point_index,
    input  logic signed [COORD_W-1:0]  coord_x,
    input  logic signed [COORD_W-1:0]  coord_y,
    input  logic signed [COORD_W-1:0]  coord_z,
    output sts_t                       sts,
    output logic [IDX_W-1:0]           best_idx,
    output logic [DIST_W-1:0]          best_d
);

    localparam int WORD_W = 3 * COORD_W;

    logic [WORD_W-1:0] mem [MAX_POINTS];

    logic                      wr_ok;
    logic [WORD_W-1:0]         rd_data_reg;

    logic signed [COORD_W-1:0] loc_x_reg;
    logic signed [COORD_W-1:0] loc_y_reg;
    logic signed [COORD_W-1:0] loc_z_reg;

    logic                      s1_valid_reg;
    logic                      s1_init_reg;
    logic [IDX_W-1:0]          s1_idx_reg;
    logic                      s2_valid_reg;
    logic                      s2_init_reg;
    logic [IDX_W-1:0]          s2_idx_reg;
    logic                      s3_valid_reg;
    logic                      s3_init_reg;
    logic [IDX_W-1:0]          s3_idx_reg;
    logic                      s4_valid_reg;
    logic                      s4_init_reg;
    logic [IDX_W-1:0]          s4_idx_reg;

    logic [MAG_W-1:0]          mag_x_reg;
    logic [MAG_W-1:0]          mag_y_reg;
    logic [MAG_W-1:0]          mag_z_reg;
    logic [MAG_W-1:0]          mag_x_next;
    logic [MAG_W-1:0]          mag_y_next;
    logic [MAG_W-1:0]          mag_z_next;
    logic [SQ_W-1:0]           sq_x_reg;
    logic [SQ_W-1:0]           sq_y_reg;
    logic [SQ_W-1:0]           sq_z_reg;
    logic [DIST_W-1:0]         sum_reg;
    logic [DIST_W-1:0]         sum_next;

    logic [IDX_W-1:0]          best_idx_reg;
    logic [DIST_W-1:0]         best_d_reg;

    function automatic logic [MAG_W-1:0] abs_diff(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [COORD_W:0] d;
        logic        [COORD_W:0] m;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        m = d[COORD_W] ? (~d + 1'b1) : d;
        return m[MAG_W-1:0];
    endfunction

    assign wr_ok = cmd.wr_en && (32'(point_index) < 32'(MAX_POINTS));

    // point table
    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            mem[IDX_W'(point_index)] <= {coord_x, coord_y, coord_z};
        end
        if (cmd.issue)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        mag_x_next = abs_diff(loc_x_reg, rd_data_reg[3*COORD_W-1:2*COORD_W]);
        mag_y_next = abs_diff(loc_y_reg, rd_data_reg[2*COORD_W-1:COORD_W]);
        mag_z_next = abs_diff(loc_z_reg, rd_data_reg[COORD_W-1:0]);
        sum_next   = DIST_W'(sq_x_reg) + DIST_W'(sq_y_reg) + DIST_W'(sq_z_reg);
    end

    // distance pipeline: read, magnitude, square, sum, compare
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loc_x_reg    <= '0;
            loc_y_reg    <= '0;
            loc_z_reg    <= '0;
            s1_valid_reg <= 1'b0;
            s1_init_reg  <= 1'b0;
            s1_idx_reg   <= '0;
            s2_valid_reg <= 1'b0;
            s2_init_reg  <= 1'b0;
            s2_idx_reg   <= '0;
            s3_valid_reg <= 1'b0;
            s3_init_reg  <= 1'b0;
            s3_idx_reg   <= '0;
            s4_valid_reg <= 1'b0;
            s4_init_reg  <= 1'b0;
            s4_idx_reg   <= '0;
            mag_x_reg    <= '0;
            mag_y_reg    <= '0;
            mag_z_reg    <= '0;
            sq_x_reg     <= '0;
            sq_y_reg     <= '0;
            sq_z_reg     <= '0;
            sum_reg      <= '0;
            best_idx_reg <= '0;
            best_d_reg   <= '0;
        end
        else
        begin
            if (cmd.load_loc)
            begin
                loc_x_reg <= coord_x;
                loc_y_reg <= coord_y;
                loc_z_reg <= coord_z;
            end

            s1_valid_reg <= cmd.issue;
            s1_init_reg  <= cmd.init;
            s1_idx_reg   <= rd_addr;

            s2_valid_reg <= s1_valid_reg;
            s2_init_reg  <= s1_init_reg;
            s2_idx_reg   <= s1_idx_reg;
            mag_x_reg    <= mag_x_next;
            mag_y_reg    <= mag_y_next;
            mag_z_reg    <= mag_z_next;

            s3_valid_reg <= s2_valid_reg;
            s3_init_reg  <= s2_init_reg;
            s3_idx_reg   <= s2_idx_reg;
            sq_x_reg     <= mag_x_reg * mag_x_reg;
            sq_y_reg     <= mag_y_reg * mag_y_reg;
            sq_z_reg     <= mag_z_reg * mag_z_reg;

            s4_valid_reg <= s3_valid_reg;
            s4_init_reg  <= s3_init_reg;
            s4_idx_reg   <= s3_idx_reg;
            sum_reg      <= sum_next;

            // strict less-than keeps the earliest on ties
            if (s4_valid_reg && (s4_init_reg || (sum_reg < best_d_reg)))
            begin
                best_d_reg   <= sum_reg;
                best_idx_reg <= s4_idx_reg;
            end
        end
    end

    assign sts.pipe_busy = s1_valid_reg | s2_valid_reg | s3_valid_reg | s4_valid_reg;
    assign sts.far       = best_d_reg > FAR_THRESHOLD_SQ;
    assign best_idx      = best_idx_reg;
    assign best_d        = best_d_reg;

endmodule

### hdl/wnwt_ctrl.sv
module wnwt_ctrl
    import wnwt_pkg::*;
#(
    parameter int MAX_POINTS  = 1024,
    parameter int BACK_RADIUS = 2,
    parameter int FWD_RADIUS  = 12,
    localparam int IDX_W = $clog2(MAX_POINTS),
    localparam int CNT_W = $clog2(MAX_POINTS + 1),
    localparam int SUM_W = $clog2(MAX_POINTS + FWD_RADIUS + BACK_RADIUS + 1)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [1:0]               req_type,
    output logic                     busy,
    input  logic                     cfg_valid,
    input  logic [CNT_IN_W-1:0]      cfg_data,
    output cmd_t                     cmd,
    output logic [IDX_W-1:0]         rd_addr,
    input  sts_t                     sts,
    input  logic [IDX_W-1:0]         best_idx,
    input  logic [DIST_W-1:0]        best_d,
    output logic                     result_valid,
    output logic [IDX_OUT_W-1:0]     nearest_index,
    output logic [DIST_W-1:0]        nearest_dist_sq,
    output logic                     used_full_scan
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WIN_FIRST,
        ST_WIN,
        ST_WIN_DRAIN,
        ST_SCAN,
        ST_SCAN_DRAIN
    } state_t;

    state_t                 state_reg;
    logic [IDX_W-1:0]       tracked_reg;
    logic [CNT_IN_W-1:0]    count_reg;
    logic [IDX_W-1:0]       t_reg;
    logic [IDX_W-1:0]       addr_reg;
    logic [IDX_W-1:0]       hi_reg;
    logic [IDX_W-1:0]       last_reg;
    logic                   full_reg;
    logic                   result_valid_reg;
    logic [IDX_OUT_W-1:0]   nearest_index_reg;
    logic [DIST_W-1:0]      nearest_dist_sq_reg;
    logic                   used_full_scan_reg;

    logic                   accept;
    req_t                   req;
    logic [CNT_W-1:0]       n_c;
    logic [CNT_W-1:0]       n_m1_c;
    logic [IDX_W-1:0]       t_c;
    logic [SUM_W-1:0]       t_s;
    logic [SUM_W-1:0]       lo_s;
    logic [SUM_W-1:0]       hi_s;
    logic [SUM_W-1:0]       last_s;
    logic                   finish;

    assign req    = req_t'(req_type);
    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = state_reg != ST_IDLE;

    always_comb
    begin
        // used count clamped to the table size
        if (32'(count_reg) > 32'(MAX_POINTS))
        begin
            n_c = CNT_W'(MAX_POINTS);
        end
        else
        begin
            n_c = CNT_W'(count_reg);
        end
        n_m1_c = n_c - 1'b1;
        if (CNT_W'(tracked_reg) > n_m1_c)
        begin
            t_c = IDX_W'(n_m1_c);
        end
        else
        begin
            t_c = tracked_reg;
        end

        t_s    = SUM_W'(t_reg);
        last_s = SUM_W'(last_reg);
        if (t_s > SUM_W'(BACK_RADIUS))
        begin
            lo_s = t_s - SUM_W'(BACK_RADIUS);
        end
        else
        begin
            lo_s = '0;
        end
        hi_s = t_s + SUM_W'(FWD_RADIUS);
        if (hi_s > last_s)
        begin
            hi_s = last_s;
        end
    end

    always_comb
    begin
        cmd.wr_en    = accept && (req == REQ_WRITE);
        cmd.load_loc = accept && (req == REQ_QUERY);
        cmd.issue    = (state_reg == ST_WIN_FIRST) || (state_reg == ST_WIN)
                       || (state_reg == ST_SCAN);
        cmd.init     = state_reg == ST_WIN_FIRST;
        rd_addr      = (state_reg == ST_WIN_FIRST) ? t_reg : addr_reg;
    end

    assign finish = ((state_reg == ST_WIN_DRAIN) && !sts.pipe_busy && !sts.far)
                    || ((state_reg == ST_SCAN_DRAIN) && !sts.pipe_busy);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            tracked_reg         <= '0;
            count_reg           <= '0;
            t_reg               <= '0;
            addr_reg            <= '0;
            hi_reg              <= '0;
            last_reg            <= '0;
            full_reg            <= 1'b0;
            result_valid_reg    <= 1'b0;
            nearest_index_reg   <= '0;
            nearest_dist_sq_reg <= '0;
            used_full_scan_reg  <= 1'b0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            if (cfg_valid)
            begin
                count_reg <= cfg_data;
            end
            if (finish)
            begin
                result_valid_reg    <= 1'b1;
                nearest_index_reg   <= IDX_OUT_W'(best_idx);
                nearest_dist_sq_reg <= best_d;
                used_full_scan_reg  <= full_reg;
                tracked_reg         <= best_idx;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (req)
                            REQ_QUERY:
                            begin
                                full_reg <= 1'b0;
                                if (n_c == '0)
                                begin
                                    result_valid_reg    <= 1'b1;
                                    nearest_index_reg   <= '0;
                                    nearest_dist_sq_reg <= '0;
                                    used_full_scan_reg  <= 1'b0;
                                end
                                else
                                begin
                                    t_reg     <= t_c;
                                    last_reg  <= IDX_W'(n_m1_c);
                                    state_reg <= ST_WIN_FIRST;
                                end
                            end
                            REQ_RESTART:
                            begin
                                tracked_reg <= '0;
                            end
                            REQ_WRITE, REQ_NONE:
                            begin
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_WIN_FIRST:
                begin
                    addr_reg  <= IDX_W'(lo_s);
                    hi_reg    <= IDX_W'(hi_s);
                    state_reg <= ST_WIN;
                end
                ST_WIN:
                begin
                    if (addr_reg == hi_reg)
                    begin
                        state_reg <= ST_WIN_DRAIN;
                    end
                    else
                    begin
                        addr_reg <= addr_reg + 1'b1;
                    end
                end
                ST_WIN_DRAIN:
                begin
                    if (!sts.pipe_busy)
                    begin
                        if (sts.far)
                        begin
                            full_reg  <= 1'b1;
                            addr_reg  <= t_reg;
                            state_reg <= ST_SCAN;
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (addr_reg == last_reg)
                    begin
                        state_reg <= ST_SCAN_DRAIN;
                    end
                    else
                    begin
                        addr_reg <= addr_reg + 1'b1;
                    end
                end
                ST_SCAN_DRAIN:
                begin
                    if (!sts.pipe_busy)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result_valid    = result_valid_reg;
    assign nearest_index   = nearest_index_reg;
    assign nearest_dist_sq = nearest_dist_sq_reg;
    assign used_full_scan  = used_full_scan_reg;

    a_win_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WIN) |-> (addr_reg <= hi_reg))
        else $error("window address past its end");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (full_reg && (addr_reg <= last_reg)))
        else $error("scan address past last point or flag clear");

    a_track_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (t_reg <= last_reg))
        else $error("tracked index not clamped");

    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) && ($past(state_reg) != ST_IDLE)
        |-> ($past(sts.pipe_busy) == 1'b0))
        else $error("result taken before pipeline drained");

endmodule
